// File: rtl/dsort_pkg.sv
// Package for the descending exchange sort: sizes, record and word types.
`timescale 1ns / 1ps

package dsort_pkg;

    // Store capacity and the index and count widths that follow from it
    localparam int MAX_ENTRIES = 32;
    localparam int IDX_W       = $clog2(MAX_ENTRIES);
    localparam int CNT_W       = $clog2(MAX_ENTRIES + 1);

    localparam int KEY_W = 16;
    localparam int TAG_W = 8;

    // One stored record
    typedef struct packed {
        logic [KEY_W-1:0] key;
        logic [TAG_W-1:0] tag;
    } rec_t;

    // Input word
    typedef struct packed {
        logic [KEY_W-1:0] sales_count;
        logic [TAG_W-1:0] record_tag;
        logic             last_item;
    } in_word_t;

    // Result word
    typedef struct packed {
        logic [KEY_W-1:0] sorted_sales;
        logic [TAG_W-1:0] sorted_tag;
        logic             final_record;
        logic             overflow_seen;
    } out_word_t;

    // Result request from the sequencer to the output register
    typedef struct packed {
        logic      valid;
        out_word_t word;
    } emit_t;

endpackage

// File: rtl/dsort_cmp.sv
// Compare-exchange unit: keeps the larger key, releases the other record.
`timescale 1ns / 1ps

module dsort_cmp
    import dsort_pkg::*;
(
    input  rec_t held,
    input  rec_t fetched,
    output logic swap,
    output rec_t keep_rec,
    output rec_t put_rec
);

    // Swap only on a strictly larger fetched key, so equal keys stay put
    assign swap     = (held.key < fetched.key);
    assign keep_rec = swap ? fetched : held;
    assign put_rec  = swap ? held : fetched;

endmodule

// File: rtl/dsort_seq.sv
// Record store and sequencer: load, exchange sort and ordered emission.
`timescale 1ns / 1ps

module dsort_seq
    import dsort_pkg::*;
(
    input  logic     clk,
    input  logic     rst_n,
    input  logic     start,
    input  in_word_t item,
    output logic     busy,
    output emit_t    emit
);

    localparam logic [2:0] S_IDLE  = 3'd0;
    localparam logic [2:0] S_LOADI = 3'd1;
    localparam logic [2:0] S_TAKEI = 3'd2;
    localparam logic [2:0] S_RDJ   = 3'd3;
    localparam logic [2:0] S_CMP   = 3'd4;
    localparam logic [2:0] S_EMIT  = 3'd5;

    rec_t mem [MAX_ENTRIES];

    logic [2:0]       state_reg, state_next;
    logic [CNT_W-1:0] fill_reg, fill_next;
    logic             ovf_reg, ovf_next;
    logic [IDX_W-1:0] i_reg, i_next;
    logic [IDX_W-1:0] j_reg, j_next;
    rec_t             held_reg, held_next;
    rec_t             rd_data_reg;

    logic             accept;
    logic             room;
    logic [IDX_W-1:0] rd_addr;
    logic             wr_en;
    logic [IDX_W-1:0] wr_addr;
    rec_t             wr_data;
    logic             swap;
    rec_t             keep_rec;
    rec_t             put_rec;
    logic             i_last;
    logic             j_last;

    dsort_cmp u_cmp (
        .held     (held_reg),
        .fetched  (rd_data_reg),
        .swap     (swap),
        .keep_rec (keep_rec),
        .put_rec  (put_rec)
    );

    assign busy   = (state_reg != S_IDLE);
    assign accept = start && !busy;
    assign room   = (fill_reg < CNT_W'(MAX_ENTRIES));
    assign i_last = ((CNT_W'(i_reg) + CNT_W'(1)) == fill_reg);
    assign j_last = ((CNT_W'(j_reg) + CNT_W'(1)) == fill_reg);

    // Pick the read address: position i when it opens, position j during the scan
    always_comb
    begin
        rd_addr = j_reg;
        if (state_reg == S_LOADI)
        begin
            rd_addr = i_reg;
        end
    end

    // Write port: store an incoming record, or put back the released one
    always_comb
    begin
        wr_en   = 1'b0;
        wr_addr = j_reg;
        wr_data = put_rec;
        if (state_reg == S_IDLE)
        begin
            wr_en   = accept && room;
            wr_addr = fill_reg[IDX_W-1:0];
            wr_data = '{key: item.sales_count, tag: item.record_tag};
        end
        else if (state_reg == S_CMP)
        begin
            wr_en = swap;
        end
    end

    // Record memory, registered read
    always_ff @(posedge clk)
    begin
        if (wr_en)
        begin
            mem[wr_addr] <= wr_data;
        end
        rd_data_reg <= mem[rd_addr];
    end

    // Sequencer next state
    always_comb
    begin
        state_next = state_reg;
        fill_next  = fill_reg;
        ovf_next   = ovf_reg;
        i_next     = i_reg;
        j_next     = j_reg;
        held_next  = held_reg;
        emit       = '0;

        unique case (state_reg)
            S_IDLE:
            begin
                if (accept)
                begin
                    if (room)
                    begin
                        fill_next = fill_reg + CNT_W'(1);
                    end
                    else
                    begin
                        ovf_next = 1'b1;
                    end
                    if (item.last_item)
                    begin
                        i_next     = '0;
                        state_next = S_LOADI;
                    end
                end
            end
            S_LOADI:
            begin
                state_next = S_TAKEI;
            end
            S_TAKEI:
            begin
                // Hold record i; scan the later positions unless i is the last one
                held_next = rd_data_reg;
                if (i_last)
                begin
                    state_next = S_EMIT;
                end
                else
                begin
                    j_next     = i_reg + IDX_W'(1);
                    state_next = S_RDJ;
                end
            end
            S_RDJ:
            begin
                state_next = S_CMP;
            end
            S_CMP:
            begin
                held_next = keep_rec;
                if (j_last)
                begin
                    state_next = S_EMIT;
                end
                else
                begin
                    j_next     = j_reg + IDX_W'(1);
                    state_next = S_RDJ;
                end
            end
            S_EMIT:
            begin
                // Position i is settled: send it out and advance
                emit.valid              = 1'b1;
                emit.word.sorted_sales  = held_reg.key;
                emit.word.sorted_tag    = held_reg.tag;
                emit.word.final_record  = i_last;
                emit.word.overflow_seen = ovf_reg;
                if (i_last)
                begin
                    fill_next  = '0;
                    ovf_next   = 1'b0;
                    state_next = S_IDLE;
                end
                else
                begin
                    i_next     = i_reg + IDX_W'(1);
                    state_next = S_LOADI;
                end
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    // Control registers
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= S_IDLE;
            fill_reg  <= '0;
            ovf_reg   <= 1'b0;
            i_reg     <= '0;
            j_reg     <= '0;
        end
        else
        begin
            state_reg <= state_next;
            fill_reg  <= fill_next;
            ovf_reg   <= ovf_next;
            i_reg     <= i_next;
            j_reg     <= j_next;
        end
    end

    // Held record, payload only
    always_ff @(posedge clk)
    begin
        held_reg <= held_next;
    end

endmodule

// File: rtl/descending_exchange_sort_top.sv
// Top level of the descending exchange sort with its result register.
`timescale 1ns / 1ps

// Records load one word per cycle while busy is low; a word with last_item
// set closes the set and raises busy. The set of N stored records is then
// sorted by a single compare-exchange unit fed from a one-read-port record
// memory: each position takes a read of record i and a take, then a read and
// a compare for each later position, and last an emit to the result register.
// Results leave in descending key order, one word per result_valid pulse,
// with final_record on the last; the receiver cannot stall, so every pulse
// must be taken. Words beyond MAX_ENTRIES are dropped and overflow_seen is
// set on every result of that set. busy falls in the cycle of the final
// result, and the next word may be given then.
module descending_exchange_sort_top
    import dsort_pkg::*;
(
    input  logic      clk,
    input  logic      rst_n,
    input  logic      start,
    input  in_word_t  item,
    output logic      busy,
    output out_word_t result,
    output logic      result_valid
);

    emit_t     emit;
    out_word_t result_reg;
    logic      result_valid_reg;

    dsort_seq u_seq (
        .clk   (clk),
        .rst_n (rst_n),
        .start (start),
        .item  (item),
        .busy  (busy),
        .emit  (emit)
    );

    // Register the result word and its strobe
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            result_valid_reg <= 1'b0;
        end
        else
        begin
            result_valid_reg <= emit.valid;
        end
    end

    always_ff @(posedge clk)
    begin
        if (emit.valid)
        begin
            result_reg <= emit.word;
        end
    end

    assign result       = result_reg;
    assign result_valid = result_valid_reg;

endmodule

// File: rtl/dsort_chk.sv
// Port checker for the descending exchange sort, bound to the top level.
`timescale 1ns / 1ps

module dsort_chk
    import dsort_pkg::*;
(
    input logic      clk,
    input logic      rst_n,
    input logic      start,
    input in_word_t  item,
    input logic      busy,
    input out_word_t result,
    input logic      result_valid
);

    // A closing word starts the sort
    a_close_busy: assert property (@(posedge clk) disable iff (!rst_n)
        (start && !busy && item.last_item) |=> busy)
        else $error("busy not raised after a closing word");

    // An ordinary word is taken without raising busy
    a_load_idle: assert property (@(posedge clk) disable iff (!rst_n)
        (start && !busy && !item.last_item) |=> !busy)
        else $error("busy raised by a non-closing word");

    // Results come only out of a sort
    a_result_busy: assert property (@(posedge clk) disable iff (!rst_n)
        result_valid |-> $past(busy))
        else $error("result word without a sort in progress");

    // The final result ends the sort
    a_final_idle: assert property (@(posedge clk) disable iff (!rst_n)
        (result_valid && result.final_record) |-> !busy)
        else $error("busy still high at the final result");

endmodule

bind descending_exchange_sort_top dsort_chk u_chk (.*);

// File: verif/testbench.sv
// Self-checking testbench for the descending exchange sort top level.
`timescale 1ns / 1ps

module testbench;
    import dsort_pkg::*;

    // Longest run of cycles with no word taken in or given out, with a wide margin
    // over a full sort of 32 records
    localparam int STALL_LIMIT = 6000;
    localparam int RANDOM_WORDS = 420;

    logic      clk;
    logic      rst_n;
    logic      start;
    in_word_t  item;
    logic      busy;
    out_word_t result;
    logic      result_valid;

    // Shadow of the record store and set status
    logic [KEY_W-1:0] model_keys [MAX_ENTRIES];
    logic [TAG_W-1:0] model_tags [MAX_ENTRIES];
    int               stored_count;
    logic             dropped_any;

    // Sorted records still owed by the block, oldest first
    out_word_t pending_records [$];

    int  words_sent;
    int  sets_closed;
    int  sets_overflowed;
    int  results_checked;
    int  failures;
    int  idle_cycles;
    bit  no_idle;

    descending_exchange_sort_top dut (
        .clk          (clk),
        .rst_n        (rst_n),
        .start        (start),
        .item         (item),
        .busy         (busy),
        .result       (result),
        .result_valid (result_valid)
    );

    // Clock
    initial clk = 1'b0;
    always #1 clk = ~clk;

    // Sort the shadow store the way the block does and queue the run
    task automatic close_set();
        logic [KEY_W-1:0] k_tmp;
        logic [TAG_W-1:0] t_tmp;
        out_word_t        w;
        for (int i = 0; i + 1 < stored_count; i++)
        begin
            for (int j = i + 1; j < stored_count; j++)
            begin
                if (model_keys[i] < model_keys[j])
                begin
                    k_tmp         = model_keys[i];
                    t_tmp         = model_tags[i];
                    model_keys[i] = model_keys[j];
                    model_tags[i] = model_tags[j];
                    model_keys[j] = k_tmp;
                    model_tags[j] = t_tmp;
                end
            end
        end
        for (int k = 0; k < stored_count; k++)
        begin
            w.sorted_sales  = model_keys[k];
            w.sorted_tag    = model_tags[k];
            w.final_record  = (k + 1 == stored_count);
            w.overflow_seen = dropped_any;
            pending_records.push_back(w);
        end
        sets_closed++;
        if (dropped_any)
            sets_overflowed++;
        stored_count = 0;
        dropped_any  = 1'b0;
    endtask

    // Store or drop one accepted record; close the set on the last one
    task automatic absorb_record(input in_word_t w);
        if (stored_count < MAX_ENTRIES)
        begin
            model_keys[stored_count] = w.sales_count;
            model_tags[stored_count] = w.record_tag;
            stored_count++;
        end
        else
        begin
            dropped_any = 1'b1;
        end
        if (w.last_item)
            close_set();
    endtask

    function automatic int draw_gap();
        return no_idle ? 0 : $urandom_range(0, 6);
    endfunction

    // Offer one word after a gap and hold it until the block takes it
    task automatic send_record(input logic [KEY_W-1:0] key, input logic [TAG_W-1:0] tag,
                               input logic last);
        int       gap;
        in_word_t w;
        gap           = draw_gap();
        w.sales_count = key;
        w.record_tag  = tag;
        w.last_item   = last;
        repeat (gap) @(negedge clk) start <= 1'b0;
        @(negedge clk);
        start <= 1'b1;
        item  <= w;
        do
            @(posedge clk);
        while (busy);
        words_sent++;
        absorb_record(w);
    endtask

    // Send a whole set of n records with random tags and the given key spread
    task automatic send_set(input int n, input bit narrow_keys);
        logic [KEY_W-1:0] key;
        for (int i = 0; i < n; i++)
        begin
            key = narrow_keys ? KEY_W'($urandom_range(0, 3)) : KEY_W'($urandom);
            send_record(key, TAG_W'($urandom), i == n - 1);
        end
    endtask

    // Check every result word against the oldest sorted record owed
    always @(posedge clk)
    begin
        out_word_t want;
        if (rst_n && result_valid)
        begin
            if (pending_records.size() == 0)
            begin
                $error("unexpected result word: sales %h tag %h", result.sorted_sales,
                       result.sorted_tag);
                failures++;
            end
            else
            begin
                want = pending_records.pop_front();
                results_checked++;
                if (result.sorted_sales !== want.sorted_sales)
                begin
                    $error("sorted_sales: expected %h, got %h", want.sorted_sales,
                           result.sorted_sales);
                    failures++;
                end
                if (result.sorted_tag !== want.sorted_tag)
                begin
                    $error("sorted_tag: expected %h, got %h", want.sorted_tag,
                           result.sorted_tag);
                    failures++;
                end
                if (result.final_record !== want.final_record)
                begin
                    $error("final_record: expected %b, got %b", want.final_record,
                           result.final_record);
                    failures++;
                end
                if (result.overflow_seen !== want.overflow_seen)
                begin
                    $error("overflow_seen: expected %b, got %b", want.overflow_seen,
                           result.overflow_seen);
                    failures++;
                end
            end
        end
    end

    // Abort when nothing moves for too long
    always @(posedge clk)
    begin
        if (!rst_n || (start && !busy) || result_valid)
            idle_cycles <= 0;
        else
            idle_cycles <= idle_cycles + 1;
        if (idle_cycles >= STALL_LIMIT)
        begin
            $display("timeout: %0d records still owed", pending_records.size());
            $display("FAIL descending_exchange_sort_top");
            $finish;
        end
    end

    // Extreme keys and tags, every bit both ways
    task automatic test_extremes();
        send_record(16'h0000, 8'hFF, 1'b0);
        send_record(16'hFFFF, 8'h00, 1'b0);
        send_record(16'h5555, 8'hAA, 1'b0);
        send_record(16'hAAAA, 8'h55, 1'b0);
        send_record(16'h0001, 8'h01, 1'b0);
        send_record(16'h8000, 8'h80, 1'b1);
    endtask

    // Set of one record closed by its only word
    task automatic test_single_record();
        send_record(16'h1234, 8'h42, 1'b1);
    endtask

    // Equal keys mixed with others: the exchange order decides the tags
    task automatic test_equal_keys();
        send_record(16'h0100, 8'h01, 1'b0);
        send_record(16'h0100, 8'h02, 1'b0);
        send_record(16'h0200, 8'h03, 1'b0);
        send_record(16'h0100, 8'h04, 1'b0);
        send_record(16'h0050, 8'h05, 1'b0);
        send_record(16'h0100, 8'h06, 1'b1);
    endtask

    // Store filled exactly, no drop
    task automatic test_full_store();
        send_set(MAX_ENTRIES, 1'b0);
    endtask

    // Store overrun; the closing word itself is dropped but still ends the set
    task automatic test_overflow();
        send_set(MAX_ENTRIES + 2, 1'b1);
    endtask

    // Random sets, mostly short, a few near or past capacity, some with many ties
    task automatic test_random_sets();
        int target;
        int n;
        target = words_sent + RANDOM_WORDS;
        while (words_sent < target)
        begin
            no_idle = ($urandom_range(0, 3) == 0);
            if ($urandom_range(0, 9) == 0)
                n = $urandom_range(MAX_ENTRIES - 2, MAX_ENTRIES + 8);
            else
                n = $urandom_range(1, 12);
            send_set(n, $urandom_range(0, 2) == 0);
        end
        no_idle = 1'b0;
    endtask

    initial
    begin
        rst_n           = 1'b0;
        start           = 1'b0;
        item            = '0;
        stored_count    = 0;
        dropped_any     = 1'b0;
        words_sent      = 0;
        sets_closed     = 0;
        sets_overflowed = 0;
        results_checked = 0;
        failures        = 0;
        idle_cycles     = 0;
        no_idle         = 1'b0;
        repeat (5) @(posedge clk);
        @(negedge clk) rst_n = 1'b1;

        test_extremes();
        test_single_record();
        test_equal_keys();
        test_full_store();
        test_overflow();
        test_random_sets();

        // Drain outstanding results, then watch for stray ones
        @(negedge clk) start <= 1'b0;
        while (pending_records.size() != 0)
            @(posedge clk);
        repeat (100) @(posedge clk);

        $display("sent %0d words in %0d sets (%0d overrun), checked %0d sorted results",
                 words_sent, sets_closed, sets_overflowed, results_checked);
        if (failures == 0 && pending_records.size() == 0)
            $display("PASS descending_exchange_sort_top");
        else
            $display("FAIL descending_exchange_sort_top");
        $finish;
    end

endmodule
